FILE: sv/lupds_pkg.sv
package lupds_pkg;

    localparam int Q_W        = 32;
    localparam int IDX_W      = 5;
    localparam int LANE_LIMIT = 16;

    localparam logic signed [Q_W-1:0] Q_MAX = 32'sh7fff_ffff;
    localparam logic signed [Q_W-1:0] Q_MIN = 32'sh8000_0000;

    typedef enum logic [1:0] {
        OP_LOAD_A = 2'd0,
        OP_DECOMP = 2'd1,
        OP_LOAD_B = 2'd2,
        OP_SOLVE  = 2'd3
    } op_t;

    localparam logic KIND_DET = 1'b0;
    localparam logic KIND_X   = 1'b1;

    typedef struct packed {
        logic                  go;
        logic signed [Q_W-1:0] num;
        logic signed [Q_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic                  done;
        logic signed [Q_W-1:0] quot;
    } div_rsp_t;

endpackage

FILE: sv/lupds_div.sv
module lupds_div #(
    parameter int FRAC_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  lupds_pkg::div_req_t req,
    output lupds_pkg::div_rsp_t rsp
);

    localparam int NW = lupds_pkg::Q_W + FRAC_BITS;
    localparam int CW = $clog2(NW + 1);

    typedef enum logic [1:0] {
        D_IDLE,
        D_RUN,
        D_FIN
    } dstate_t;

    dstate_t           state_reg;
    logic [CW-1:0]     cnt_reg;
    logic [NW-1:0]     num_reg;
    logic [31:0]       rem_reg;
    logic [31:0]       den_reg;
    logic              neg_reg;
    logic              done_reg;
    logic signed [31:0] quot_reg;

    logic [32:0] rem_sh;
    logic        ge;
    logic [32:0] rem_sub;
    logic [31:0] mag_a;
    logic [31:0] mag_b;
    logic        ovf;

    assign mag_a   = req.num[31] ? 32'(-req.num) : 32'(req.num);
    assign mag_b   = req.den[31] ? 32'(-req.den) : 32'(req.den);
    assign rem_sh  = {rem_reg, num_reg[NW-1]};
    assign ge      = rem_sh >= {1'b0, den_reg};
    assign rem_sub = rem_sh - {1'b0, den_reg};
    assign ovf     = |num_reg[NW-1:31];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
            cnt_reg   <= '0;
            num_reg   <= '0;
            rem_reg   <= '0;
            den_reg   <= '0;
            neg_reg   <= 1'b0;
            done_reg  <= 1'b0;
            quot_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                D_IDLE:
                begin
                    if (req.go)
                    begin
                        if (req.den == '0)
                        begin
                            done_reg <= 1'b1;
                            if (req.num == '0)
                                quot_reg <= '0;
                            else if (!req.num[31])
                                quot_reg <= lupds_pkg::Q_MAX;
                            else
                                quot_reg <= lupds_pkg::Q_MIN;
                        end
                        else
                        begin
                            num_reg   <= {mag_a, {FRAC_BITS{1'b0}}};
                            den_reg   <= mag_b;
                            rem_reg   <= '0;
                            neg_reg   <= req.num[31] ^ req.den[31];
                            cnt_reg   <= CW'(NW);
                            state_reg <= D_RUN;
                        end
                    end
                end
                D_RUN:
                begin
                    rem_reg <= ge ? rem_sub[31:0] : rem_sh[31:0];
                    num_reg <= {num_reg[NW-2:0], ge};
                    cnt_reg <= cnt_reg - CW'(1);
                    if (cnt_reg == CW'(1))
                        state_reg <= D_FIN;
                end
                D_FIN:
                begin
                    done_reg  <= 1'b1;
                    state_reg <= D_IDLE;
                    if (neg_reg)
                        quot_reg <= ovf ? lupds_pkg::Q_MIN : -$signed(num_reg[31:0]);
                    else
                        quot_reg <= ovf ? lupds_pkg::Q_MAX : $signed(num_reg[31:0]);
                end
                default:
                    state_reg <= D_IDLE;
            endcase
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;

endmodule

FILE: sv/lup_decompose_and_solve.sv
// LU factorization with partial pivoting and linear solve, signed fixed point.
// Input channel (in_valid/in_stall) carries one word per request: opcode,
// row, col, value. Matrix and right-hand loads are accepted back to back;
// they return nothing.
// Decompose factors the stored matrix in place and returns one word with the
// determinant. Solve returns n words, x[0] .. x[n-1], last set on the final one.
// While a decompose or solve runs, in_stall stays high. Their length is set by
// the matrix memory and the bit-serial divider: decompose spends its time on
// the elimination updates, one divide per multiplier and the row swaps; solve
// on forward and back substitution, one divide per unknown and the result
// words.
// Output channel (out_valid/out_stall) is a registered word; a stalled word
// holds, and the sequencer waits until the slot frees.
// size_in_use must be written through cfg_valid/cfg_ready only while idle,
// not enforced by the block; n is the register clamped to 1 .. min(MAX_SIDE,16).
// Reset: row order identity, sign positive, singular clear, size register = 16.
// Matrix and right-hand stores are undefined until loaded.
module lup_decompose_and_solve #(
    parameter int MAX_SIDE  = 16,
    parameter int FRAC_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         opcode,
    input  logic [3:0]         row,
    input  logic [3:0]         col,
    input  logic signed [31:0] value,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               result_kind,
    output logic [3:0]         index,
    output logic signed [31:0] result_value,
    output logic               singular,
    output logic               last,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [4:0]         size_in_use
);

    localparam int CAP   = (MAX_SIDE < lupds_pkg::LANE_LIMIT) ? MAX_SIDE
                                                              : lupds_pkg::LANE_LIMIT;
    localparam int CW    = $clog2(CAP);
    localparam int AW    = 2 * CW;
    localparam int DEPTH = 1 << AW;
    localparam int IW    = lupds_pkg::IDX_W;
    localparam int ACC_W = 32 + IW;

    typedef enum logic [5:0] {
        S_IDLE,
        S_PS_RD, S_PS_CMP, S_PS_END,
        S_SW_RDA, S_SW_RDB, S_SW_WA, S_SW_WB,
        S_EL_PIV_RD, S_EL_PIV, S_EL_RDA, S_EL_DIVGO, S_EL_DIVW,
        S_EL_RDU, S_EL_MUL, S_EL_Q, S_EL_WR, S_NEXTK,
        S_DT_RD, S_DT_MUL, S_DT_Q, S_EMIT_D,
        S_FW_ROW, S_FW_RD, S_FW_MUL, S_FW_ACC, S_FW_END,
        S_BK_ROW, S_BK_RD, S_BK_MUL, S_BK_ACC, S_BK_DRD, S_BK_DIVGO, S_BK_DIVW,
        S_XO, S_ZO
    } state_t;

    state_t                    state_reg;
    logic [4:0]                size_reg;
    logic [IW-1:0]             n_reg, k_reg, i_reg, j_reg, best_reg;
    logic [31:0]               bmag_reg;
    logic signed [31:0]        piv_reg, tmp_reg, f_reg, det_reg;
    logic signed [63:0]        prod_reg;
    logic signed [31:0]        qm_reg;
    logic signed [ACC_W-1:0]   acc_reg;
    logic                      parity_reg, sing_reg;
    logic [CW-1:0]             ro_reg [CAP];
    logic signed [31:0]        rhs_reg [CAP];
    logic signed [31:0]        wv_reg [CAP];
    logic                      ov_reg, kind_reg, last_reg, osing_reg;
    logic [3:0]                idx_reg;
    logic signed [31:0]        oval_reg;

    logic signed [31:0]        lu_mem [DEPTH];
    logic signed [31:0]        mem_q;
    logic                      mem_we, mem_re;
    logic [AW-1:0]             mem_wa, mem_ra;
    logic signed [31:0]        mem_wd;

    lupds_pkg::div_req_t       dreq;
    lupds_pkg::div_rsp_t       drsp;

    logic                      acc_in, slot_free, emit_go;
    logic [IW-1:0]             n_now, wv_idx;
    logic signed [31:0]        wv_rd, rhs_b, mul_a, qm, diff_a, sat_d;
    logic signed [ACC_W-1:0]   diff_b;
    logic signed [ACC_W:0]     diff;
    logic [31:0]               mag_q;
    logic                      rhs_we, wv_we;
    logic [CW-1:0]             rhs_wa, wv_wa;
    logic signed [31:0]        wv_wd;

    function automatic logic [AW-1:0] mk_addr(input logic [IW-1:0] r,
                                              input logic [IW-1:0] c);
        return {r[CW-1:0], c[CW-1:0]};
    endfunction

    function automatic logic signed [31:0] qsat(input logic signed [63:0] p);
        logic [63:0] mag;
        logic [63:0] sh;
        mag = p[63] ? 64'(-p) : 64'(p);
        sh  = mag >> FRAC_BITS;
        if (p[63])
            return (|sh[63:31]) ? lupds_pkg::Q_MIN : -$signed(sh[31:0]);
        return (|sh[63:31]) ? lupds_pkg::Q_MAX : $signed(sh[31:0]);
    endfunction

    function automatic logic signed [31:0] sat_w(input logic signed [ACC_W:0] v);
        if (v > $signed({{(ACC_W-31){1'b0}}, 32'h7fff_ffff}))
            return lupds_pkg::Q_MAX;
        if (v < $signed({{(ACC_W-31){1'b1}}, 32'h8000_0000}))
            return lupds_pkg::Q_MIN;
        return v[31:0];
    endfunction

    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != S_IDLE);
    assign acc_in    = in_valid && !in_stall;
    assign slot_free = !ov_reg || !out_stall;
    assign emit_go   = slot_free && (state_reg inside {S_EMIT_D, S_XO, S_ZO});

    assign n_now = (size_reg == 5'd0) ? IW'(1) :
                   (size_reg > 5'(CAP)) ? IW'(CAP) : IW'(size_reg);

    assign wv_idx = (state_reg == S_FW_MUL || state_reg == S_BK_MUL) ? j_reg : i_reg;
    assign wv_rd  = wv_reg[wv_idx[CW-1:0]];
    assign rhs_b  = rhs_reg[ro_reg[i_reg[CW-1:0]]];
    assign mag_q  = mem_q[31] ? 32'(-mem_q) : 32'(mem_q);
    assign qm     = qsat(prod_reg);

    always_comb
    begin
        case (state_reg)
            S_EL_MUL: mul_a = f_reg;
            S_DT_MUL: mul_a = det_reg;
            default:  mul_a = wv_rd;
        endcase
    end

    always_comb
    begin
        case (state_reg)
            S_FW_END:
            begin
                diff_a = rhs_b;
                diff_b = acc_reg;
            end
            S_BK_DRD:
            begin
                diff_a = wv_rd;
                diff_b = acc_reg;
            end
            default:
            begin
                diff_a = mem_q;
                diff_b = {{(ACC_W-32){qm_reg[31]}}, qm_reg};
            end
        endcase
        diff  = {{(ACC_W-31){diff_a[31]}}, diff_a} - {diff_b[ACC_W-1], diff_b};
        sat_d = sat_w(diff);
    end

    always_comb
    begin
        mem_we = 1'b0;
        mem_wa = '0;
        mem_wd = mem_q;
        mem_re = 1'b0;
        mem_ra = '0;
        case (state_reg)
            S_IDLE:
            begin
                mem_wd = value;
                mem_wa = mk_addr({1'b0, row}, {1'b0, col});
                mem_we = acc_in && opcode == lupds_pkg::OP_LOAD_A
                         && {1'b0, row} < IW'(CAP) && {1'b0, col} < IW'(CAP);
            end
            S_PS_RD:
            begin
                mem_re = 1'b1;
                mem_ra = mk_addr(i_reg, k_reg);
            end
            S_SW_RDA:
            begin
                mem_re = 1'b1;
                mem_ra = mk_addr(k_reg, j_reg);
            end
            S_SW_RDB:
            begin
                mem_re = 1'b1;
                mem_ra = mk_addr(best_reg, j_reg);
            end
            S_SW_WA:
            begin
                mem_we = 1'b1;
                mem_wa = mk_addr(k_reg, j_reg);
            end
            S_SW_WB:
            begin
                mem_we = 1'b1;
                mem_wa = mk_addr(best_reg, j_reg);
                mem_wd = tmp_reg;
            end
            S_EL_PIV_RD:
            begin
                mem_re = 1'b1;
                mem_ra = mk_addr(k_reg, k_reg);
            end
            S_EL_RDA:
            begin
                mem_re = 1'b1;
                mem_ra = mk_addr(i_reg, k_reg);
            end
            S_EL_DIVW:
            begin
                mem_we = drsp.done;
                mem_wa = mk_addr(i_reg, k_reg);
                mem_wd = drsp.quot;
            end
            S_EL_RDU:
            begin
                mem_re = 1'b1;
                mem_ra = mk_addr(k_reg, j_reg);
            end
            S_EL_MUL:
            begin
                mem_re = 1'b1;
                mem_ra = mk_addr(i_reg, j_reg);
            end
            S_EL_WR:
            begin
                mem_we = 1'b1;
                mem_wa = mk_addr(i_reg, j_reg);
                mem_wd = sat_d;
            end
            S_DT_RD:
            begin
                mem_re = 1'b1;
                mem_ra = mk_addr(i_reg, i_reg);
            end
            S_FW_RD, S_BK_RD:
            begin
                mem_re = 1'b1;
                mem_ra = mk_addr(i_reg, j_reg);
            end
            S_BK_DRD:
            begin
                mem_re = 1'b1;
                mem_ra = mk_addr(i_reg, i_reg);
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            lu_mem[mem_wa] <= mem_wd;
        if (mem_re)
            mem_q <= lu_mem[mem_ra];
    end

    assign dreq.go  = (state_reg == S_EL_DIVGO) || (state_reg == S_BK_DIVGO);
    assign dreq.num = (state_reg == S_EL_DIVGO) ? mem_q : tmp_reg;
    assign dreq.den = (state_reg == S_EL_DIVGO) ? piv_reg : mem_q;

    lupds_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dreq),
        .rsp   (drsp)
    );

    assign rhs_we = acc_in && opcode == lupds_pkg::OP_LOAD_B && {1'b0, row} < IW'(CAP);
    assign rhs_wa = row[CW-1:0];

    always_comb
    begin
        wv_we = 1'b0;
        wv_wa = i_reg[CW-1:0];
        wv_wd = sat_d;
        if (state_reg == S_FW_END)
            wv_we = 1'b1;
        else if (state_reg == S_BK_DIVW && drsp.done)
        begin
            wv_we = 1'b1;
            wv_wd = drsp.quot;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rhs_we)
            rhs_reg[rhs_wa] <= value;
        if (wv_we)
            wv_reg[wv_wa] <= wv_wd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            size_reg   <= 5'd16;
            n_reg      <= '0;
            k_reg      <= '0;
            i_reg      <= '0;
            j_reg      <= '0;
            best_reg   <= '0;
            bmag_reg   <= '0;
            piv_reg    <= '0;
            tmp_reg    <= '0;
            f_reg      <= '0;
            det_reg    <= '0;
            prod_reg   <= '0;
            qm_reg     <= '0;
            acc_reg    <= '0;
            parity_reg <= 1'b0;
            sing_reg   <= 1'b0;
            ov_reg     <= 1'b0;
            kind_reg   <= 1'b0;
            last_reg   <= 1'b0;
            osing_reg  <= 1'b0;
            idx_reg    <= '0;
            oval_reg   <= '0;
            for (int r = 0; r < CAP; r++)
                ro_reg[r] <= CW'(r);
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                size_reg <= size_in_use;
            if (ov_reg && !out_stall && !emit_go)
                ov_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (acc_in && opcode == lupds_pkg::OP_DECOMP)
                    begin
                        n_reg      <= n_now;
                        k_reg      <= '0;
                        i_reg      <= '0;
                        best_reg   <= '0;
                        bmag_reg   <= '0;
                        parity_reg <= 1'b0;
                        sing_reg   <= 1'b0;
                        for (int r = 0; r < CAP; r++)
                            ro_reg[r] <= CW'(r);
                        state_reg  <= S_PS_RD;
                    end
                    else if (acc_in && opcode == lupds_pkg::OP_SOLVE)
                    begin
                        n_reg     <= n_now;
                        i_reg     <= '0;
                        state_reg <= sing_reg ? S_ZO : S_FW_ROW;
                    end
                end
                S_PS_RD:
                    state_reg <= S_PS_CMP;
                S_PS_CMP:
                begin
                    if (mag_q > bmag_reg)
                    begin
                        bmag_reg <= mag_q;
                        best_reg <= i_reg;
                    end
                    if (i_reg + IW'(1) == n_reg)
                        state_reg <= S_PS_END;
                    else
                    begin
                        i_reg     <= i_reg + IW'(1);
                        state_reg <= S_PS_RD;
                    end
                end
                S_PS_END:
                begin
                    if (bmag_reg == '0)
                    begin
                        sing_reg  <= 1'b1;
                        det_reg   <= '0;
                        state_reg <= S_EMIT_D;
                    end
                    else if (best_reg != k_reg)
                    begin
                        ro_reg[k_reg[CW-1:0]]    <= ro_reg[best_reg[CW-1:0]];
                        ro_reg[best_reg[CW-1:0]] <= ro_reg[k_reg[CW-1:0]];
                        parity_reg <= !parity_reg;
                        j_reg      <= '0;
                        state_reg  <= S_SW_RDA;
                    end
                    else
                        state_reg <= S_EL_PIV_RD;
                end
                S_SW_RDA:
                    state_reg <= S_SW_RDB;
                S_SW_RDB:
                begin
                    tmp_reg   <= mem_q;
                    state_reg <= S_SW_WA;
                end
                S_SW_WA:
                    state_reg <= S_SW_WB;
                S_SW_WB:
                begin
                    if (j_reg == IW'(CAP - 1))
                        state_reg <= S_EL_PIV_RD;
                    else
                    begin
                        j_reg     <= j_reg + IW'(1);
                        state_reg <= S_SW_RDA;
                    end
                end
                S_EL_PIV_RD:
                    state_reg <= S_EL_PIV;
                S_EL_PIV:
                begin
                    piv_reg   <= mem_q;
                    i_reg     <= k_reg + IW'(1);
                    state_reg <= (k_reg + IW'(1) == n_reg) ? S_NEXTK : S_EL_RDA;
                end
                S_EL_RDA:
                    state_reg <= S_EL_DIVGO;
                S_EL_DIVGO:
                    state_reg <= S_EL_DIVW;
                S_EL_DIVW:
                begin
                    if (drsp.done)
                    begin
                        f_reg     <= drsp.quot;
                        j_reg     <= k_reg + IW'(1);
                        state_reg <= S_EL_RDU;
                    end
                end
                S_EL_RDU:
                    state_reg <= S_EL_MUL;
                S_EL_MUL:
                begin
                    prod_reg  <= mul_a * mem_q;
                    state_reg <= S_EL_Q;
                end
                S_EL_Q:
                begin
                    qm_reg    <= qm;
                    state_reg <= S_EL_WR;
                end
                S_EL_WR:
                begin
                    if (j_reg + IW'(1) != n_reg)
                    begin
                        j_reg     <= j_reg + IW'(1);
                        state_reg <= S_EL_RDU;
                    end
                    else if (i_reg + IW'(1) != n_reg)
                    begin
                        i_reg     <= i_reg + IW'(1);
                        state_reg <= S_EL_RDA;
                    end
                    else
                        state_reg <= S_NEXTK;
                end
                S_NEXTK:
                begin
                    if (k_reg + IW'(1) == n_reg)
                    begin
                        det_reg   <= parity_reg ? -(32'sd1 <<< FRAC_BITS)
                                                : (32'sd1 <<< FRAC_BITS);
                        i_reg     <= '0;
                        state_reg <= S_DT_RD;
                    end
                    else
                    begin
                        k_reg     <= k_reg + IW'(1);
                        i_reg     <= k_reg + IW'(1);
                        best_reg  <= k_reg + IW'(1);
                        bmag_reg  <= '0;
                        state_reg <= S_PS_RD;
                    end
                end
                S_DT_RD:
                    state_reg <= S_DT_MUL;
                S_DT_MUL:
                begin
                    prod_reg  <= mul_a * mem_q;
                    state_reg <= S_DT_Q;
                end
                S_DT_Q:
                begin
                    det_reg <= qm;
                    if (i_reg + IW'(1) == n_reg)
                        state_reg <= S_EMIT_D;
                    else
                    begin
                        i_reg     <= i_reg + IW'(1);
                        state_reg <= S_DT_RD;
                    end
                end
                S_EMIT_D:
                begin
                    if (slot_free)
                    begin
                        ov_reg    <= 1'b1;
                        kind_reg  <= lupds_pkg::KIND_DET;
                        idx_reg   <= '0;
                        oval_reg  <= det_reg;
                        osing_reg <= sing_reg;
                        last_reg  <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                end
                S_FW_ROW:
                begin
                    acc_reg   <= '0;
                    j_reg     <= '0;
                    state_reg <= (i_reg == '0) ? S_FW_END : S_FW_RD;
                end
                S_FW_RD:
                    state_reg <= S_FW_MUL;
                S_FW_MUL:
                begin
                    prod_reg  <= mul_a * mem_q;
                    state_reg <= S_FW_ACC;
                end
                S_FW_ACC:
                begin
                    acc_reg <= acc_reg + {{(ACC_W-32){qm[31]}}, qm};
                    if (j_reg + IW'(1) == i_reg)
                        state_reg <= S_FW_END;
                    else
                    begin
                        j_reg     <= j_reg + IW'(1);
                        state_reg <= S_FW_RD;
                    end
                end
                S_FW_END:
                begin
                    if (i_reg + IW'(1) == n_reg)
                        state_reg <= S_BK_ROW;
                    else
                    begin
                        i_reg     <= i_reg + IW'(1);
                        state_reg <= S_FW_ROW;
                    end
                end
                S_BK_ROW:
                begin
                    acc_reg   <= '0;
                    j_reg     <= i_reg + IW'(1);
                    state_reg <= (i_reg + IW'(1) == n_reg) ? S_BK_DRD : S_BK_RD;
                end
                S_BK_RD:
                    state_reg <= S_BK_MUL;
                S_BK_MUL:
                begin
                    prod_reg  <= mul_a * mem_q;
                    state_reg <= S_BK_ACC;
                end
                S_BK_ACC:
                begin
                    acc_reg <= acc_reg + {{(ACC_W-32){qm[31]}}, qm};
                    if (j_reg + IW'(1) == n_reg)
                        state_reg <= S_BK_DRD;
                    else
                    begin
                        j_reg     <= j_reg + IW'(1);
                        state_reg <= S_BK_RD;
                    end
                end
                S_BK_DRD:
                begin
                    tmp_reg   <= sat_d;
                    state_reg <= S_BK_DIVGO;
                end
                S_BK_DIVGO:
                    state_reg <= S_BK_DIVW;
                S_BK_DIVW:
                begin
                    if (drsp.done)
                    begin
                        if (i_reg == '0)
                            state_reg <= S_XO;
                        else
                        begin
                            i_reg     <= i_reg - IW'(1);
                            state_reg <= S_BK_ROW;
                        end
                    end
                end
                S_XO, S_ZO:
                begin
                    if (slot_free)
                    begin
                        ov_reg    <= 1'b1;
                        kind_reg  <= lupds_pkg::KIND_X;
                        idx_reg   <= i_reg[3:0];
                        oval_reg  <= (state_reg == S_XO) ? wv_rd : 32'sd0;
                        osing_reg <= sing_reg;
                        last_reg  <= (i_reg + IW'(1) == n_reg);
                        if (i_reg + IW'(1) == n_reg)
                            state_reg <= S_IDLE;
                        else
                            i_reg <= i_reg + IW'(1);
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign out_valid    = ov_reg;
    assign result_kind  = kind_reg;
    assign index        = idx_reg;
    assign result_value = oval_reg;
    assign singular     = osing_reg;
    assign last         = last_reg;

endmodule

FILE: sv/lupds_chk.sv
module lupds_chk (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic [1:0]         opcode,
    input logic               out_valid,
    input logic               out_stall,
    input logic               result_kind,
    input logic signed [31:0] result_value,
    input logic               singular,
    input logic               last
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("stalled word dropped");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(result_value))
        else $error("stalled word changed");

    a_det_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && result_kind == lupds_pkg::KIND_DET |-> last)
        else $error("determinant word without last");

    a_sing_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && singular && result_kind == lupds_pkg::KIND_X |-> result_value == 32'sd0)
        else $error("nonzero solution on singular matrix");

    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall
        && (opcode == lupds_pkg::OP_DECOMP || opcode == lupds_pkg::OP_SOLVE)
        |=> in_stall)
        else $error("input not held off during request");

endmodule

bind lup_decompose_and_solve lupds_chk u_lupds_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .opcode       (opcode),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .result_kind  (result_kind),
    .result_value (result_value),
    .singular     (singular),
    .last         (last)
);

FILE: dv/lup_decompose_and_solve_checker.sv
module lup_decompose_and_solve_checker
    import lupds_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic [1:0]         opcode,
    input  logic [3:0]         row,
    input  logic [3:0]         col,
    input  logic signed [31:0] value,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic               result_kind,
    input  logic [3:0]         index,
    input  logic signed [31:0] result_value,
    input  logic               singular,
    input  logic               last,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [4:0]         size_in_use,
    output int                 mismatches,
    output int                 outstanding
);

    typedef struct {
        logic               kind;
        logic [3:0]         idx;
        logic signed [31:0] val;
        logic               sing;
        logic               fin;
    } result_word_t;

    localparam longint FULL_POS = 64'sh7fff_ffff;
    localparam longint FULL_NEG = -64'sh8000_0000;

    logic signed [31:0] mat[16][16];
    logic signed [31:0] rhs[16];
    logic signed [31:0] xvec[16];
    logic [3:0]         perm[16];
    logic               odd_swaps;
    logic               zero_pivot;
    logic [4:0]         side_reg;
    result_word_t       expected_words[$];

    assign outstanding = expected_words.size();

    function automatic int side_now();
        int n;
        n = side_reg;
        if (n < 1) n = 1;
        if (n > 16) n = 16;
        return n;
    endfunction

    function automatic logic signed [31:0] clip(longint v);
        if (v > FULL_POS) return Q_MAX;
        if (v < FULL_NEG) return Q_MIN;
        return v[31:0];
    endfunction

    function automatic logic signed [31:0] signed_mag(bit neg, longint m);
        if (!neg) return (m > FULL_POS) ? Q_MAX : m[31:0];
        if (m >= 64'sh8000_0000) return Q_MIN;
        return clip(-m);
    endfunction

    function automatic logic signed [31:0] fx_mul(logic signed [31:0] a, logic signed [31:0] b);
        longint p;
        longint m;
        p = longint'(a) * longint'(b);
        m = (p < 0) ? -p : p;
        return signed_mag(p < 0, m >> 16);
    endfunction

    function automatic logic signed [31:0] fx_div(logic signed [31:0] a, logic signed [31:0] b);
        longint ma;
        longint mb;
        if (b == 0) begin
            if (a == 0) return 0;
            return (a > 0) ? Q_MAX : Q_MIN;
        end
        ma = (a < 0) ? -longint'(a) : longint'(a);
        mb = (b < 0) ? -longint'(b) : longint'(b);
        return signed_mag((a < 0) != (b < 0), (ma << 16) / mb);
    endfunction

    function automatic longint abs_of(logic signed [31:0] a);
        return (a < 0) ? -longint'(a) : longint'(a);
    endfunction

    task automatic factor_in_place(int n);
        int best;
        longint best_mag;
        logic signed [31:0] t;
        logic [3:0] o;
        logic signed [31:0] f;
        for (int i = 0; i < 16; i++) perm[i] = i[3:0];
        odd_swaps = 0;
        zero_pivot = 0;
        for (int k = 0; k < n; k++) begin
            best = k;
            best_mag = abs_of(mat[k][k]);
            for (int i = k + 1; i < n; i++) begin
                if (abs_of(mat[i][k]) > best_mag) begin
                    best = i;
                    best_mag = abs_of(mat[i][k]);
                end
            end
            if (best_mag == 0) begin
                zero_pivot = 1;
                return;
            end
            if (best != k) begin
                for (int j = 0; j < 16; j++) begin
                    t = mat[k][j];
                    mat[k][j] = mat[best][j];
                    mat[best][j] = t;
                end
                o = perm[k];
                perm[k] = perm[best];
                perm[best] = o;
                odd_swaps = !odd_swaps;
            end
            for (int i = k + 1; i < n; i++) begin
                f = fx_div(mat[i][k], mat[k][k]);
                mat[i][k] = f;
                for (int j = k + 1; j < n; j++)
                    mat[i][j] = clip(longint'(mat[i][j]) - longint'(fx_mul(f, mat[k][j])));
            end
        end
    endtask

    task automatic push_word(logic kind, int idx, logic signed [31:0] v, bit fin);
        result_word_t w;
        w.kind = kind;
        w.idx  = idx[3:0];
        w.val  = v;
        w.sing = zero_pivot;
        w.fin  = fin;
        expected_words.push_back(w);
    endtask

    task automatic apply_request(op_t op, logic [3:0] r, logic [3:0] c, logic signed [31:0] v);
        int n;
        logic signed [31:0] det;
        longint acc;
        n = side_now();
        case (op)
            OP_LOAD_A: mat[r][c] = v;
            OP_LOAD_B: rhs[r] = v;
            OP_DECOMP:
            begin
                factor_in_place(n);
                det = 0;
                if (!zero_pivot) begin
                    det = odd_swaps ? -32'sh1_0000 : 32'sh1_0000;
                    for (int i = 0; i < n; i++) det = fx_mul(det, mat[i][i]);
                end
                push_word(KIND_DET, 0, det, 1);
            end
            OP_SOLVE:
            begin
                if (!zero_pivot) begin
                    for (int i = 0; i < n; i++) begin
                        acc = 0;
                        for (int j = 0; j < i; j++) acc += fx_mul(mat[i][j], xvec[j]);
                        xvec[i] = clip(longint'(rhs[perm[i]]) - acc);
                    end
                    for (int i = n - 1; i >= 0; i--) begin
                        acc = 0;
                        for (int j = i + 1; j < n; j++) acc += fx_mul(mat[i][j], xvec[j]);
                        xvec[i] = fx_div(clip(longint'(xvec[i]) - acc), mat[i][i]);
                    end
                end
                for (int i = 0; i < n; i++)
                    push_word(KIND_X, i, zero_pivot ? 32'sd0 : xvec[i], i == n - 1);
            end
        endcase
    endtask

    task automatic check_word();
        result_word_t w;
        if (expected_words.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result word: kind %0d index %0d value %h",
                         result_kind, index, result_value);
            return;
        end
        w = expected_words.pop_front();
        if (result_kind !== w.kind || index !== w.idx || result_value !== w.val
            || singular !== w.sing || last !== w.fin) begin
            mismatches++;
            if (mismatches <= 10)
                $display("result mismatch: exp kind %0d idx %0d val %h sing %0d last %0d, got kind %0d idx %0d val %h sing %0d last %0d",
                         w.kind, w.idx, w.val, w.sing, w.fin,
                         result_kind, index, result_value, singular, last);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 16; i++) perm[i] = i[3:0];
            odd_swaps = 0;
            zero_pivot = 0;
            side_reg = 5'd16;
            expected_words.delete();
            mismatches = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready) side_reg = size_in_use;
            if (in_valid && !in_stall) apply_request(op_t'(opcode), row, col, value);
            if (out_valid && !out_stall) check_word();
        end
    end

endmodule

FILE: dv/lup_decompose_and_solve_tb.sv
module lup_decompose_and_solve_tb;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [1:0]         opcode;
    logic [3:0]         row;
    logic [3:0]         col;
    logic signed [31:0] value;
    logic               out_valid;
    logic               out_stall;
    logic               result_kind;
    logic [3:0]         index;
    logic signed [31:0] result_value;
    logic               singular;
    logic               last;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [4:0]         size_in_use;
    int                 mismatches;
    int                 outstanding;
    int                 requests_sent;
    bit                 calm;

    lup_decompose_and_solve dut (.*);

    lup_decompose_and_solve_checker checker_i (.*);

    initial
    begin
        clk = 0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #8000000;
        $display("== FAIL ==");
        $finish;
    end

    function automatic bit idle_roll();
        return !calm && $urandom_range(99) < 17;
    endfunction

    always @(posedge clk) out_stall <= idle_roll();

    task automatic send_word(lupds_pkg::op_t op, int r, int c, logic signed [31:0] v);
        while (idle_roll())
        begin
            in_valid <= 0;
            @(posedge clk);
        end
        in_valid <= 1;
        opcode   <= op;
        row      <= r[3:0];
        col      <= c[3:0];
        value    <= v;
        do @(posedge clk); while (in_stall);
        requests_sent++;
    endtask

    task automatic settle();
        in_valid <= 0;
        @(posedge clk);
        while (outstanding != 0 || in_stall) @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    task automatic set_side(int s);
        settle();
        cfg_valid   <= 1;
        size_in_use <= s[4:0];
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 0;
    endtask

    function automatic logic signed [31:0] modest();
        return $signed($urandom_range(32'h10_0000)) - 32'sh8_0000;
    endfunction

    task automatic load_block(int n, int style);
        logic signed [31:0] v;
        int zc;
        zc = $urandom_range(n - 1);
        for (int r = 0; r < n; r++)
            for (int c = 0; c < n; c++)
            begin
                case (style)
                    0: v = modest();
                    1: v = (c == zc) ? 32'sd0 : modest();
                    default: v = $urandom;
                endcase
                if (style == 0 && r == c && $urandom_range(1)) v = v + 32'sh20_0000;
                send_word(lupds_pkg::OP_LOAD_A, r, c, v);
            end
        for (int r = 0; r < n; r++)
            send_word(lupds_pkg::OP_LOAD_B, r, 0, style == 2 ? $urandom : modest());
    endtask

    initial
    begin
        int n;
        int pick;
        int phase;
        rst_n = 0;
        in_valid = 0;
        opcode = lupds_pkg::OP_LOAD_A;
        row = 0;
        col = 0;
        value = 0;
        cfg_valid = 0;
        size_in_use = 16;
        requests_sent = 0;
        calm = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        for (int r = 0; r < 16; r++)
            for (int c = 0; c < 16; c++)
                send_word(lupds_pkg::OP_LOAD_A, r, c,
                          (r == c) ? 32'sh3_0000 + modest() : $urandom);
        for (int r = 0; r < 16; r++) send_word(lupds_pkg::OP_LOAD_B, r, 0, $urandom);

        // zero divisor in back substitution, solve with no factoring
        set_side(2);
        send_word(lupds_pkg::OP_LOAD_A, 1, 1, 0);
        send_word(lupds_pkg::OP_LOAD_B, 0, 0, 32'sh7fff_ffff);
        send_word(lupds_pkg::OP_LOAD_B, 1, 0, 32'sh8000_0000);
        send_word(lupds_pkg::OP_SOLVE, 0, 0, 0);
        // extreme values, saturation
        send_word(lupds_pkg::OP_LOAD_A, 0, 0, 32'sh8000_0000);
        send_word(lupds_pkg::OP_LOAD_A, 0, 1, 32'sh7fff_ffff);
        send_word(lupds_pkg::OP_LOAD_A, 1, 0, 32'sh7fff_ffff);
        send_word(lupds_pkg::OP_LOAD_A, 1, 1, 32'sh0000_0001);
        send_word(lupds_pkg::OP_DECOMP, 0, 0, 0);
        send_word(lupds_pkg::OP_SOLVE, 0, 0, 0);
        send_word(lupds_pkg::OP_DECOMP, 0, 0, 0);
        // singular matrix, then solve after singular
        send_word(lupds_pkg::OP_LOAD_A, 0, 0, 0);
        send_word(lupds_pkg::OP_LOAD_A, 1, 0, 0);
        send_word(lupds_pkg::OP_DECOMP, 0, 0, 0);
        send_word(lupds_pkg::OP_SOLVE, 0, 0, 0);
        set_side(0);
        send_word(lupds_pkg::OP_DECOMP, 15, 15, $urandom);
        send_word(lupds_pkg::OP_SOLVE, 15, 15, $urandom);
        set_side(31);
        send_word(lupds_pkg::OP_DECOMP, 0, 0, 0);
        send_word(lupds_pkg::OP_SOLVE, 0, 0, 0);

        phase = 0;
        while (requests_sent < 272 + 100)
        begin
            calm = (phase >= 4 && phase < 7);
            pick = $urandom_range(11);
            n = (pick == 0) ? 16 : (pick == 1) ? 0 : (pick == 2) ? $urandom_range(31, 17)
                : $urandom_range(5, 1);
            set_side(n);
            if (n < 1) n = 1;
            if (n > 16) n = 16;
            pick = $urandom_range(9);
            load_block(n, pick == 0 ? 1 : pick == 1 ? 2 : 0);
            repeat ($urandom_range(2))
                send_word(lupds_pkg::op_t'($urandom_range(1) ? lupds_pkg::OP_LOAD_A
                                                            : lupds_pkg::OP_LOAD_B),
                          $urandom_range(15), $urandom_range(15), $urandom);
            if ($urandom_range(9) != 0)
                send_word(lupds_pkg::OP_DECOMP, $urandom, $urandom, $urandom);
            repeat ($urandom_range(2, 1))
                send_word(lupds_pkg::OP_SOLVE, $urandom, $urandom, $urandom);
            phase++;
        end
        calm = 0;

        settle();
        if (mismatches == 0 && outstanding == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

FILE: filelist.f
sv/lupds_pkg.sv
sv/lupds_div.sv
sv/lup_decompose_and_solve.sv
sv/lupds_chk.sv
dv/lup_decompose_and_solve_checker.sv
dv/lup_decompose_and_solve_tb.sv
